// ----- src/pfcs_pkg.sv -----
// Package for the parallel flash command sequencer: payload structs, codes,
// command bytes and small helpers. Used by parallel_flash_command_sequencer.
`timescale 1ns / 1ps

package pfcs_pkg;

	// Probe mask range (bits of the unlock address mask)
	localparam int WIDEST_BITS_DEF = 16;
	localparam int NARROWEST_BITS_DEF = 8;

	// Result burst buffer
	localparam int RES_MAX = 7;
	localparam int RES_IDX_W = 3;

	localparam int POLL_W = 28;
	localparam int MASK_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [31:0] UNLOCK_ADDR_A = 32'h0000_5555;
	localparam logic [31:0] UNLOCK_ADDR_B = 32'h0000_2AAA;
	localparam logic [7:0] UNLOCK_BYTE_A = 8'hAA;
	localparam logic [7:0] UNLOCK_BYTE_B = 8'h55;
	localparam logic [7:0] CMD_PROGRAM = 8'hA0;
	localparam logic [7:0] CMD_ERASE_SETUP = 8'h80;
	localparam logic [7:0] CMD_CHIP_ERASE = 8'h10;
	localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;
	localparam logic [7:0] CMD_ID_ENTRY = 8'h90;
	localparam logic [7:0] CMD_ID_EXIT = 8'hF0;
	localparam int TOGGLE_BIT = 6;

	typedef enum logic [2:0] {
		OP_PROBE   = 3'd0,
		OP_PROGRAM = 3'd1,
		OP_CHIP_ER = 3'd2,
		OP_SECT_ER = 3'd3,
		OP_REPLY   = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_READ8  = 2'd1,
		ACT_READ16 = 2'd2,
		ACT_DONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE       = 2'd0,
		PH_PROBE      = 2'd1,
		PH_POLL_FIRST = 2'd2,
		PH_POLL_CMP   = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CMD_MASK  = 2'd0,
		REG_POLL_LIM  = 2'd1,
		REG_POLL_MAX  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] target_address;
		logic [7:0]  write_byte;
		logic [15:0] reply_data;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  bus_action;
		logic [31:0] bus_address;
		logic [7:0]  bus_data;
		logic        status;
		logic        chip_found;
		logic [7:0]  maker_code;
		logic [7:0]  part_code;
		logic [15:0] probed_mask;
		logic        last;
	} res_t;

	// Mask with the low bits set
	function automatic logic [31:0] mask_of(input logic [4:0] bits);
		return (32'd1 << bits) - 32'd1;
	endfunction

	// Plain bus action, all report fields cleared
	function automatic res_t mk_res(input action_t act, input logic [31:0] addr,
			input logic [7:0] data);
		res_t r;
		r = '0;
		r.bus_action = act;
		r.bus_address = addr;
		r.bus_data = data;
		return r;
	endfunction

endpackage

// ----- src/parallel_flash_command_sequencer.sv -----
// Top level of the parallel flash command sequencer: input register, burst
// builder, result burst buffer and config registers. Depends on pfcs_pkg.
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Payload
// cmd     | in        | cmd_valid/cmd_stall | pfcs_pkg::cmd_t
// res     | out       | res_valid/res_stall | pfcs_pkg::res_t
// cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// An accepted item sits in the input register; once the buffer is free, its whole
// burst (0 to 7 results) is built combinationally and loaded into the buffer.
// The buffer drains one result per cycle while res_stall is low, and the buffer
// drain sets the item rate.
// The next item is processed in the cycle the last result of a burst transfers.
// arst_n clears the phase, counts and buffer; config registers reset to defaults.
// res_stall holds the current result; cmd_stall rises while a held item waits for the buffer.

module parallel_flash_command_sequencer #(
	parameter int WIDEST_MASK_BITS = pfcs_pkg::WIDEST_BITS_DEF,
	parameter int NARROWEST_MASK_BITS = pfcs_pkg::NARROWEST_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  pfcs_pkg::cmd_t               cmd,
	output logic                         res_valid,
	input  logic                         res_stall,
	output pfcs_pkg::res_t               res,
	input  logic                         cfg_we,
	input  logic [pfcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pfcs_pkg::POLL_W-1:0]  cfg_data
);
	import pfcs_pkg::*;

	// Input register
	logic valid_s1;
	cmd_t cmd_s1;

	// Config registers
	logic [MASK_W-1:0] cmd_mask_q;
	logic [POLL_W-1:0] poll_lim_q;
	logic [POLL_W-1:0] poll_max_q;

	// Sequencer state
	phase_t phase_q, phase_nxt;
	logic [4:0] probe_bits_q, probe_bits_nxt;
	logic [31:0] probe_base_q, probe_base_nxt;
	logic [31:0] poll_addr_q, poll_addr_nxt;
	logic prev_toggle_q, prev_toggle_nxt;
	logic [POLL_W-1:0] poll_count_q, poll_count_nxt;

	// Result buffer
	res_t buf_q [RES_MAX];
	logic [RES_IDX_W-1:0] n_q;
	logic [RES_IDX_W-1:0] rd_q;

	res_t burst [RES_MAX];
	logic [RES_IDX_W-1:0] burst_n;
	logic res_xfer, rd_at_end, buf_free, proc;

	// Handshake and buffer control
	assign res_valid = (n_q != '0);
	assign res = buf_q[rd_q];
	assign res_xfer = res_valid && !res_stall;
	assign rd_at_end = (rd_q == n_q - RES_IDX_W'(1));
	assign buf_free = (n_q == '0) || (res_xfer && rd_at_end);
	assign proc = valid_s1 && buf_free;
	assign cmd_stall = valid_s1 && !buf_free;

	// Build the burst and the next state for the held item
	always_comb begin
		logic [31:0] mask, base, addr_a, addr_b, m;
		logic [7:0] vid, did;
		logic ok, tog;
		phase_nxt = phase_q;
		probe_bits_nxt = probe_bits_q;
		probe_base_nxt = probe_base_q;
		poll_addr_nxt = poll_addr_q;
		prev_toggle_nxt = prev_toggle_q;
		poll_count_nxt = poll_count_q;
		burst_n = '0;
		for (int i = 0; i < RES_MAX; i++) begin
			burst[i] = '0;
		end
		m = {16'd0, cmd_mask_q};
		base = cmd_s1.target_address & ~m;
		mask = m;
		vid = cmd_s1.reply_data[7:0];
		did = cmd_s1.reply_data[15:8];
		ok = (^vid) && (^did);
		tog = cmd_s1.reply_data[TOGGLE_BIT];
		addr_a = '0;
		addr_b = '0;
		case (cmd_s1.opcode)
			OP_PROBE: begin
				if (phase_q == PH_IDLE) begin
					probe_bits_nxt = 5'(WIDEST_MASK_BITS);
					probe_base_nxt = cmd_s1.target_address;
					mask = mask_of(5'(WIDEST_MASK_BITS));
					base = cmd_s1.target_address & ~mask;
					addr_a = base | (UNLOCK_ADDR_A & mask);
					addr_b = base | (UNLOCK_ADDR_B & mask);
					burst[0] = mk_res(ACT_WRITE, addr_a, UNLOCK_BYTE_A);
					burst[1] = mk_res(ACT_WRITE, addr_b, UNLOCK_BYTE_B);
					burst[2] = mk_res(ACT_WRITE, addr_a, CMD_ID_ENTRY);
					burst[3] = mk_res(ACT_READ16, base, 8'd0);
					burst_n = RES_IDX_W'(4);
					phase_nxt = PH_PROBE;
				end
			end
			OP_PROGRAM: begin
				if (phase_q == PH_IDLE) begin
					addr_a = base | (UNLOCK_ADDR_A & m);
					addr_b = base | (UNLOCK_ADDR_B & m);
					burst[0] = mk_res(ACT_WRITE, addr_a, UNLOCK_BYTE_A);
					burst[1] = mk_res(ACT_WRITE, addr_b, UNLOCK_BYTE_B);
					burst[2] = mk_res(ACT_WRITE, addr_a, CMD_PROGRAM);
					burst[3] = mk_res(ACT_WRITE, cmd_s1.target_address,
						cmd_s1.write_byte);
					burst[4] = mk_res(ACT_READ8, base, 8'd0);
					burst_n = RES_IDX_W'(5);
					poll_addr_nxt = base;
					phase_nxt = PH_POLL_FIRST;
				end
			end
			OP_CHIP_ER: begin
				if (phase_q == PH_IDLE) begin
					base = cmd_s1.target_address;
					addr_a = base | (UNLOCK_ADDR_A & m);
					addr_b = base | (UNLOCK_ADDR_B & m);
					burst[0] = mk_res(ACT_WRITE, addr_a, UNLOCK_BYTE_A);
					burst[1] = mk_res(ACT_WRITE, addr_b, UNLOCK_BYTE_B);
					burst[2] = mk_res(ACT_WRITE, addr_a, CMD_ERASE_SETUP);
					burst[3] = mk_res(ACT_WRITE, addr_a, UNLOCK_BYTE_A);
					burst[4] = mk_res(ACT_WRITE, addr_b, UNLOCK_BYTE_B);
					burst[5] = mk_res(ACT_WRITE, addr_a, CMD_CHIP_ERASE);
					burst[6] = mk_res(ACT_READ8, base, 8'd0);
					burst_n = RES_IDX_W'(7);
					poll_addr_nxt = base;
					phase_nxt = PH_POLL_FIRST;
				end
			end
			OP_SECT_ER: begin
				if (phase_q == PH_IDLE) begin
					addr_a = base | (UNLOCK_ADDR_A & m);
					addr_b = base | (UNLOCK_ADDR_B & m);
					burst[0] = mk_res(ACT_WRITE, addr_a, UNLOCK_BYTE_A);
					burst[1] = mk_res(ACT_WRITE, addr_b, UNLOCK_BYTE_B);
					burst[2] = mk_res(ACT_WRITE, addr_a, CMD_ERASE_SETUP);
					burst[3] = mk_res(ACT_WRITE, addr_a, UNLOCK_BYTE_A);
					burst[4] = mk_res(ACT_WRITE, addr_b, UNLOCK_BYTE_B);
					burst[5] = mk_res(ACT_WRITE, base | cmd_s1.target_address,
						CMD_SECTOR_ERASE);
					burst[6] = mk_res(ACT_READ8, base, 8'd0);
					burst_n = RES_IDX_W'(7);
					poll_addr_nxt = base;
					phase_nxt = PH_POLL_FIRST;
				end
			end
			OP_REPLY: begin
				case (phase_q)
					PH_PROBE: begin
						if (!ok && probe_bits_q > 5'(NARROWEST_MASK_BITS)
								&& probe_bits_q != 5'd0) begin
							// Retry with one mask bit fewer
							probe_bits_nxt = probe_bits_q - 5'd1;
							mask = mask_of(probe_bits_q - 5'd1);
							base = probe_base_q & ~mask;
							addr_a = base | (UNLOCK_ADDR_A & mask);
							addr_b = base | (UNLOCK_ADDR_B & mask);
							burst[0] = mk_res(ACT_WRITE, addr_a, UNLOCK_BYTE_A);
							burst[1] = mk_res(ACT_WRITE, addr_b, UNLOCK_BYTE_B);
							burst[2] = mk_res(ACT_WRITE, addr_a, CMD_ID_ENTRY);
							burst[3] = mk_res(ACT_READ16, base, 8'd0);
						end else begin
							// Leave ID mode and report
							mask = mask_of(probe_bits_q);
							base = probe_base_q & ~mask;
							addr_a = base | (UNLOCK_ADDR_A & mask);
							addr_b = base | (UNLOCK_ADDR_B & mask);
							burst[0] = mk_res(ACT_WRITE, addr_a, UNLOCK_BYTE_A);
							burst[1] = mk_res(ACT_WRITE, addr_b, UNLOCK_BYTE_B);
							burst[2] = mk_res(ACT_WRITE, addr_a, CMD_ID_EXIT);
							burst[3] = mk_res(ACT_DONE, base, 8'd0);
							burst[3].chip_found = ok;
							burst[3].maker_code = vid;
							burst[3].part_code = did;
							burst[3].probed_mask = mask[15:0];
							phase_nxt = PH_IDLE;
						end
						burst_n = RES_IDX_W'(4);
					end
					PH_POLL_FIRST: begin
						prev_toggle_nxt = tog;
						burst_n = RES_IDX_W'(1);
						if (poll_max_q == '0) begin
							poll_count_nxt = '0;
							burst[0] = mk_res(ACT_DONE, poll_addr_q, 8'd0);
							burst[0].status = 1'b1;
							phase_nxt = PH_IDLE;
						end else begin
							poll_count_nxt = POLL_W'(1);
							burst[0] = mk_res(ACT_READ8, poll_addr_q, 8'd0);
							phase_nxt = PH_POLL_CMP;
						end
					end
					PH_POLL_CMP: begin
						burst_n = RES_IDX_W'(1);
						if (tog == prev_toggle_q) begin
							burst[0] = mk_res(ACT_DONE, poll_addr_q, 8'd0);
							burst[0].status = (poll_count_q > poll_lim_q);
							phase_nxt = PH_IDLE;
						end else begin
							prev_toggle_nxt = tog;
							if (poll_count_q < poll_max_q) begin
								poll_count_nxt = poll_count_q + POLL_W'(1);
								burst[0] = mk_res(ACT_READ8, poll_addr_q, 8'd0);
							end else begin
								burst[0] = mk_res(ACT_DONE, poll_addr_q, 8'd0);
								burst[0].status = 1'b1;
								phase_nxt = PH_IDLE;
							end
						end
					end
					default: begin
						burst_n = '0;
					end
				endcase
			end
			default: begin
				burst_n = '0;
			end
		endcase
		// Mark the final result of the burst
		for (int i = 0; i < RES_MAX; i++) begin
			if (RES_IDX_W'(i) == burst_n - RES_IDX_W'(1)) begin
				burst[i].last = 1'b1;
			end
		end
	end

	// Capture an accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_mask_q <= 16'hFFFF;
			poll_lim_q <= 28'h010_0000;
			poll_max_q <= 28'hFFF_FFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CMD_MASK: cmd_mask_q <= cfg_data[MASK_W-1:0];
				REG_POLL_LIM: poll_lim_q <= cfg_data;
				REG_POLL_MAX: poll_max_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance sequencer state when the held item is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			probe_bits_q <= 5'd16;
			probe_base_q <= '0;
			poll_addr_q <= '0;
			prev_toggle_q <= 1'b0;
			poll_count_q <= '0;
		end else if (proc) begin
			phase_q <= phase_nxt;
			probe_bits_q <= probe_bits_nxt;
			probe_base_q <= probe_base_nxt;
			poll_addr_q <= poll_addr_nxt;
			prev_toggle_q <= prev_toggle_nxt;
			poll_count_q <= poll_count_nxt;
		end
	end

	// Load a new burst or drain the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			rd_q <= '0;
		end else if (proc && burst_n != '0) begin
			n_q <= burst_n;
			rd_q <= '0;
		end else if (res_xfer) begin
			if (rd_at_end) begin
				n_q <= '0;
				rd_q <= '0;
			end else begin
				rd_q <= rd_q + RES_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc && burst_n != '0) begin
			for (int i = 0; i < RES_MAX; i++) begin
				buf_q[i] <= burst[i];
			end
		end
	end

	// A loaded burst shows at the output next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && burst_n != '0) |=> res_valid)
		else $error("loaded burst not presented");

	// A done result always closes its burst
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.bus_action == ACT_DONE) |-> res.last)
		else $error("done result not marked last");

	// A command taken while idle leaves the block busy
	a_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && phase_q == PH_IDLE && cmd_s1.opcode != OP_REPLY
			&& cmd_s1.opcode <= OP_SECT_ER) |=> (phase_q != PH_IDLE))
		else $error("command did not leave idle");

	// An empty buffer never holds off the input
	a_empty_free: assert property (@(posedge clk) disable iff (!arst_n)
		(n_q == '0) |-> !cmd_stall)
		else $error("input stalled with empty buffer");

endmodule
